@@ rtl/obb_pkg.sv @@
package obb_pkg;

    // Default field widths
    localparam int POS_WIDTH_DEF  = 20;
    localparam int AXIS_WIDTH_DEF = 16;
    localparam int LEN_WIDTH_DEF  = 16;

    // Candidate axes: 3 face axes of A, 3 face axes of B, 9 cross products
    localparam int NUM_DIM   = 3;
    localparam int NUM_AXES  = 15;
    localparam int FACE_B0   = 3;
    localparam int CROSS0    = 6;

    // Box A axis index behind cross axis n
    function automatic int cross_i(input int n);
        int r;
        if (n < CROSS0 + 3) r = 0;
        else if (n < CROSS0 + 6) r = 1;
        else r = 2;
        return r;
    endfunction

    // Box B axis index behind cross axis n
    function automatic int cross_j(input int n);
        return n - CROSS0 - NUM_DIM * cross_i(n);
    endfunction

    // Box A axis k contributes to the box A radius on axis n
    function automatic logic use_a(input int n, input int k);
        logic r;
        if (n < FACE_B0) r = 1'b0;
        else if (n < CROSS0) r = 1'b1;
        else r = (k != cross_i(n));
        return r;
    endfunction

    // Box B axis k contributes to the box B radius on axis n
    function automatic logic use_b(input int n, input int k);
        logic r;
        if (n < FACE_B0) r = 1'b1;
        else if (n < CROSS0) r = 1'b0;
        else r = (k != cross_j(n));
        return r;
    endfunction

endpackage

@@ rtl/obb_in_if.sv @@
interface obb_in_if #(
    parameter int POS_WIDTH  = obb_pkg::POS_WIDTH_DEF,
    parameter int AXIS_WIDTH = obb_pkg::AXIS_WIDTH_DEF,
    parameter int LEN_WIDTH  = obb_pkg::LEN_WIDTH_DEF
);
    logic                      valid;
    logic                      ready;
    logic [3*POS_WIDTH-1:0]    a_center;
    logic [3*AXIS_WIDTH-1:0]   a_axis_first;
    logic [3*AXIS_WIDTH-1:0]   a_axis_second;
    logic [3*AXIS_WIDTH-1:0]   a_axis_third;
    logic [3*LEN_WIDTH-1:0]    a_half_lengths;
    logic [3*POS_WIDTH-1:0]    b_center;
    logic [3*AXIS_WIDTH-1:0]   b_axis_first;
    logic [3*AXIS_WIDTH-1:0]   b_axis_second;
    logic [3*AXIS_WIDTH-1:0]   b_axis_third;
    logic [3*LEN_WIDTH-1:0]    b_half_lengths;

    modport source (
        output valid, a_center, a_axis_first, a_axis_second, a_axis_third, a_half_lengths,
               b_center, b_axis_first, b_axis_second, b_axis_third, b_half_lengths,
        input  ready
    );
    modport sink (
        input  valid, a_center, a_axis_first, a_axis_second, a_axis_third, a_half_lengths,
               b_center, b_axis_first, b_axis_second, b_axis_third, b_half_lengths,
        output ready
    );
endinterface

@@ rtl/obb_out_if.sv @@
interface obb_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

@@ rtl/obb_overlap_test.sv @@
// Channel   Role    Payload
// box_in    sink    two boxes: centers, axes, half-lengths
// res_out   source  hit
//
// Four register stages: cross axes, projections, radii, compare and result.
// One box pair per cycle unless the output stalls; the result is registered in the last stage.
// The multiply and three-term add in the projection and radius stages set the clock.
// rst_n clears the stage valid bits only; payload registers are not reset.
// Each stage advances when empty or when the next one takes its beat, so bubbles fill
// while the output is stalled.
module obb_overlap_test #(
    parameter int POS_WIDTH  = obb_pkg::POS_WIDTH_DEF,
    parameter int AXIS_WIDTH = obb_pkg::AXIS_WIDTH_DEF,
    parameter int LEN_WIDTH  = obb_pkg::LEN_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    obb_in_if.sink     box_in,
    obb_out_if.source  res_out
);
    import obb_pkg::*;

    localparam int DW = POS_WIDTH + 1;
    localparam int CW = 2 * AXIS_WIDTH + 1;
    localparam int PD = CW + POS_WIDTH + 3;
    localparam int PR = CW + AXIS_WIDTH + 2;
    localparam int RW = 3 * AXIS_WIDTH + LEN_WIDTH + 5;

    logic                          v1, r1, v2, r2, v3, r3;
    logic signed [DW-1:0]          d1 [3];
    logic signed [AXIS_WIDTH-1:0]  na1 [3][3];
    logic signed [AXIS_WIDTH-1:0]  nb1 [3][3];
    logic [LEN_WIDTH-1:0]          la1 [3];
    logic [LEN_WIDTH-1:0]          lb1 [3];
    logic signed [CW-1:0]          s1 [NUM_AXES][3];
    logic [PD-1:0]                 pd2 [NUM_AXES];
    logic [PR-1:0]                 pa2 [NUM_AXES][3];
    logic [PR-1:0]                 pb2 [NUM_AXES][3];
    logic [LEN_WIDTH-1:0]          la2 [3];
    logic [LEN_WIDTH-1:0]          lb2 [3];
    logic [PD-1:0]                 pd3 [NUM_AXES];
    logic [RW-1:0]                 ra3 [NUM_AXES];
    logic [RW-1:0]                 rb3 [NUM_AXES];

    // Stage 1: unpack, center difference, cross axes
    obb_prep #(.POS_WIDTH(POS_WIDTH), .AXIS_WIDTH(AXIS_WIDTH), .LEN_WIDTH(LEN_WIDTH)) u_prep (
        .clk, .rst_n,
        .up_valid(box_in.valid), .up_ready(box_in.ready),
        .a_center(box_in.a_center), .a_axis_first(box_in.a_axis_first),
        .a_axis_second(box_in.a_axis_second), .a_axis_third(box_in.a_axis_third),
        .a_half_lengths(box_in.a_half_lengths), .b_center(box_in.b_center),
        .b_axis_first(box_in.b_axis_first), .b_axis_second(box_in.b_axis_second),
        .b_axis_third(box_in.b_axis_third), .b_half_lengths(box_in.b_half_lengths),
        .dn_valid(v1), .dn_ready(r1),
        .d_reg(d1), .na_reg(na1), .nb_reg(nb1), .la_reg(la1), .lb_reg(lb1), .s_reg(s1)
    );

    // Stage 2: projections
    obb_proj #(.POS_WIDTH(POS_WIDTH), .AXIS_WIDTH(AXIS_WIDTH), .LEN_WIDTH(LEN_WIDTH)) u_proj (
        .clk, .rst_n,
        .up_valid(v1), .up_ready(r1),
        .d_in(d1), .na_in(na1), .nb_in(nb1), .la_in(la1), .lb_in(lb1), .s_in(s1),
        .dn_valid(v2), .dn_ready(r2),
        .pd_reg(pd2), .pa_reg(pa2), .pb_reg(pb2), .la_reg(la2), .lb_reg(lb2)
    );

    // Stage 3: radii
    obb_rad #(.POS_WIDTH(POS_WIDTH), .AXIS_WIDTH(AXIS_WIDTH), .LEN_WIDTH(LEN_WIDTH)) u_rad (
        .clk, .rst_n,
        .up_valid(v2), .up_ready(r2),
        .pd_in(pd2), .pa_in(pa2), .pb_in(pb2), .la_in(la2), .lb_in(lb2),
        .dn_valid(v3), .dn_ready(r3),
        .pd_reg(pd3), .ra_reg(ra3), .rb_reg(rb3)
    );

    // Stage 4: compare and output register
    obb_cmp #(.POS_WIDTH(POS_WIDTH), .AXIS_WIDTH(AXIS_WIDTH), .LEN_WIDTH(LEN_WIDTH)) u_cmp (
        .clk, .rst_n,
        .up_valid(v3), .up_ready(r3),
        .pd_in(pd3), .ra_in(ra3), .rb_in(rb3),
        .dn_valid(res_out.valid), .dn_ready(res_out.ready),
        .hit_reg(res_out.hit)
    );

    // Full pipeline with a stalled output takes no new beat
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1 && v2 && v3 && res_out.valid && !res_out.ready) |-> !box_in.ready)
        else $error("input accepted into a full stalled pipeline");

    // An accepted beat lands in stage 1
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (box_in.valid && box_in.ready) |=> v1)
        else $error("accepted beat lost at stage 1");

    // A new result comes only from stage 3
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_out.valid) |-> $past(v3))
        else $error("result appeared without a stage 3 beat");
endmodule

@@ rtl/obb_prep.sv @@
module obb_prep #(
    parameter int POS_WIDTH  = obb_pkg::POS_WIDTH_DEF,
    parameter int AXIS_WIDTH = obb_pkg::AXIS_WIDTH_DEF,
    parameter int LEN_WIDTH  = obb_pkg::LEN_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  up_valid,
    output logic                                  up_ready,
    input  logic [3*POS_WIDTH-1:0]                a_center,
    input  logic [3*AXIS_WIDTH-1:0]               a_axis_first,
    input  logic [3*AXIS_WIDTH-1:0]               a_axis_second,
    input  logic [3*AXIS_WIDTH-1:0]               a_axis_third,
    input  logic [3*LEN_WIDTH-1:0]                a_half_lengths,
    input  logic [3*POS_WIDTH-1:0]                b_center,
    input  logic [3*AXIS_WIDTH-1:0]               b_axis_first,
    input  logic [3*AXIS_WIDTH-1:0]               b_axis_second,
    input  logic [3*AXIS_WIDTH-1:0]               b_axis_third,
    input  logic [3*LEN_WIDTH-1:0]                b_half_lengths,
    output logic                                  dn_valid,
    input  logic                                  dn_ready,
    output logic signed [POS_WIDTH:0]             d_reg [3],
    output logic signed [AXIS_WIDTH-1:0]          na_reg [3][3],
    output logic signed [AXIS_WIDTH-1:0]          nb_reg [3][3],
    output logic [LEN_WIDTH-1:0]                  la_reg [3],
    output logic [LEN_WIDTH-1:0]                  lb_reg [3],
    output logic signed [2*AXIS_WIDTH:0]          s_reg [obb_pkg::NUM_AXES][3]
);
    import obb_pkg::*;

    localparam int DW = POS_WIDTH + 1;
    localparam int CW = 2 * AXIS_WIDTH + 1;

    logic                          valid_reg;
    logic                          adv;
    logic [3*AXIS_WIDTH-1:0]       a_raw [3];
    logic [3*AXIS_WIDTH-1:0]       b_raw [3];
    logic signed [AXIS_WIDTH-1:0]  na_next [3][3];
    logic signed [AXIS_WIDTH-1:0]  nb_next [3][3];
    logic signed [DW-1:0]          d_next [3];
    logic [LEN_WIDTH-1:0]          la_next [3];
    logic [LEN_WIDTH-1:0]          lb_next [3];
    logic signed [CW-1:0]          s_next [NUM_AXES][3];

    assign adv      = !valid_reg || dn_ready;
    assign up_ready = adv;
    assign dn_valid = valid_reg;

    // Unpack fields, form center difference and the cross-product axes
    always_comb
    begin
        a_raw[0] = a_axis_first;
        a_raw[1] = a_axis_second;
        a_raw[2] = a_axis_third;
        b_raw[0] = b_axis_first;
        b_raw[1] = b_axis_second;
        b_raw[2] = b_axis_third;
        for (int i = 0; i < 3; i++)
        begin
            d_next[i]  = DW'($signed(a_center[i*POS_WIDTH +: POS_WIDTH]))
                       - DW'($signed(b_center[i*POS_WIDTH +: POS_WIDTH]));
            la_next[i] = a_half_lengths[i*LEN_WIDTH +: LEN_WIDTH];
            lb_next[i] = b_half_lengths[i*LEN_WIDTH +: LEN_WIDTH];
            for (int k = 0; k < 3; k++)
            begin
                na_next[i][k] = $signed(a_raw[i][k*AXIS_WIDTH +: AXIS_WIDTH]);
                nb_next[i][k] = $signed(b_raw[i][k*AXIS_WIDTH +: AXIS_WIDTH]);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s_next[i][k]           = CW'(na_next[i][k]);
                s_next[FACE_B0 + i][k] = CW'(nb_next[i][k]);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s_next[CROSS0 + 3*i + j][0] = CW'(na_next[i][1]) * CW'(nb_next[j][2])
                                            - CW'(na_next[i][2]) * CW'(nb_next[j][1]);
                s_next[CROSS0 + 3*i + j][1] = CW'(na_next[i][2]) * CW'(nb_next[j][0])
                                            - CW'(na_next[i][0]) * CW'(nb_next[j][2]);
                s_next[CROSS0 + 3*i + j][2] = CW'(na_next[i][0]) * CW'(nb_next[j][1])
                                            - CW'(na_next[i][1]) * CW'(nb_next[j][0]);
            end
        end
    end

    // Hold valid across stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= up_valid;
    end

    // Capture the beat
    always_ff @(posedge clk)
    begin
        if (adv && up_valid)
        begin
            d_reg  <= d_next;
            na_reg <= na_next;
            nb_reg <= nb_next;
            la_reg <= la_next;
            lb_reg <= lb_next;
            s_reg  <= s_next;
        end
    end
endmodule

@@ rtl/obb_proj.sv @@
module obb_proj #(
    parameter int POS_WIDTH  = obb_pkg::POS_WIDTH_DEF,
    parameter int AXIS_WIDTH = obb_pkg::AXIS_WIDTH_DEF,
    parameter int LEN_WIDTH  = obb_pkg::LEN_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        up_valid,
    output logic                                        up_ready,
    input  logic signed [POS_WIDTH:0]                   d_in [3],
    input  logic signed [AXIS_WIDTH-1:0]                na_in [3][3],
    input  logic signed [AXIS_WIDTH-1:0]                nb_in [3][3],
    input  logic [LEN_WIDTH-1:0]                        la_in [3],
    input  logic [LEN_WIDTH-1:0]                        lb_in [3],
    input  logic signed [2*AXIS_WIDTH:0]                s_in [obb_pkg::NUM_AXES][3],
    output logic                                        dn_valid,
    input  logic                                        dn_ready,
    output logic [2*AXIS_WIDTH+POS_WIDTH+3:0]           pd_reg [obb_pkg::NUM_AXES],
    output logic [3*AXIS_WIDTH+2:0]                     pa_reg [obb_pkg::NUM_AXES][3],
    output logic [3*AXIS_WIDTH+2:0]                     pb_reg [obb_pkg::NUM_AXES][3],
    output logic [LEN_WIDTH-1:0]                        la_reg [3],
    output logic [LEN_WIDTH-1:0]                        lb_reg [3]
);
    import obb_pkg::*;

    localparam int CW = 2 * AXIS_WIDTH + 1;
    localparam int PD = CW + POS_WIDTH + 3;
    localparam int PR = CW + AXIS_WIDTH + 2;

    logic                  valid_reg;
    logic                  adv;
    logic signed [PD-1:0]  td;
    logic signed [PR-1:0]  ta;
    logic signed [PR-1:0]  tb;
    logic [PD-1:0]         pd_next [NUM_AXES];
    logic [PR-1:0]         pa_next [NUM_AXES][3];
    logic [PR-1:0]         pb_next [NUM_AXES][3];

    assign adv      = !valid_reg || dn_ready;
    assign up_ready = adv;
    assign dn_valid = valid_reg;

    // Project center difference and the contributing box axes onto every candidate axis
    always_comb
    begin
        td = '0;
        ta = '0;
        tb = '0;
        for (int n = 0; n < NUM_AXES; n++)
        begin
            td = PD'(s_in[n][0]) * PD'(d_in[0]) + PD'(s_in[n][1]) * PD'(d_in[1])
               + PD'(s_in[n][2]) * PD'(d_in[2]);
            pd_next[n] = td[PD-1] ? PD'(-td) : PD'(td);
            for (int k = 0; k < 3; k++)
            begin
                ta = PR'(s_in[n][0]) * PR'(na_in[k][0]) + PR'(s_in[n][1]) * PR'(na_in[k][1])
                   + PR'(s_in[n][2]) * PR'(na_in[k][2]);
                tb = PR'(s_in[n][0]) * PR'(nb_in[k][0]) + PR'(s_in[n][1]) * PR'(nb_in[k][1])
                   + PR'(s_in[n][2]) * PR'(nb_in[k][2]);
                pa_next[n][k] = !use_a(n, k) ? '0 : (ta[PR-1] ? PR'(-ta) : PR'(ta));
                pb_next[n][k] = !use_b(n, k) ? '0 : (tb[PR-1] ? PR'(-tb) : PR'(tb));
            end
        end
    end

    // Hold valid across stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= up_valid;
    end

    // Capture the beat
    always_ff @(posedge clk)
    begin
        if (adv && up_valid)
        begin
            pd_reg <= pd_next;
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            la_reg <= la_in;
            lb_reg <= lb_in;
        end
    end
endmodule

@@ rtl/obb_rad.sv @@
module obb_rad #(
    parameter int POS_WIDTH  = obb_pkg::POS_WIDTH_DEF,
    parameter int AXIS_WIDTH = obb_pkg::AXIS_WIDTH_DEF,
    parameter int LEN_WIDTH  = obb_pkg::LEN_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        up_valid,
    output logic                                        up_ready,
    input  logic [2*AXIS_WIDTH+POS_WIDTH+3:0]           pd_in [obb_pkg::NUM_AXES],
    input  logic [3*AXIS_WIDTH+2:0]                     pa_in [obb_pkg::NUM_AXES][3],
    input  logic [3*AXIS_WIDTH+2:0]                     pb_in [obb_pkg::NUM_AXES][3],
    input  logic [LEN_WIDTH-1:0]                        la_in [3],
    input  logic [LEN_WIDTH-1:0]                        lb_in [3],
    output logic                                        dn_valid,
    input  logic                                        dn_ready,
    output logic [2*AXIS_WIDTH+POS_WIDTH+3:0]           pd_reg [obb_pkg::NUM_AXES],
    output logic [3*AXIS_WIDTH+LEN_WIDTH+4:0]           ra_reg [obb_pkg::NUM_AXES],
    output logic [3*AXIS_WIDTH+LEN_WIDTH+4:0]           rb_reg [obb_pkg::NUM_AXES]
);
    import obb_pkg::*;

    localparam int RW   = 3 * AXIS_WIDTH + LEN_WIDTH + 5;
    localparam int FSH  = 2 * (AXIS_WIDTH - 2);

    logic           valid_reg;
    logic           adv;
    logic [RW-1:0]  ra_next [NUM_AXES];
    logic [RW-1:0]  rb_next [NUM_AXES];

    assign adv      = !valid_reg || dn_ready;
    assign up_ready = adv;
    assign dn_valid = valid_reg;

    // Weight projected axes by half-lengths; face axes take the half-length directly
    always_comb
    begin
        for (int n = 0; n < NUM_AXES; n++)
        begin
            ra_next[n] = RW'(pa_in[n][0]) * RW'(la_in[0]) + RW'(pa_in[n][1]) * RW'(la_in[1])
                       + RW'(pa_in[n][2]) * RW'(la_in[2]);
            rb_next[n] = RW'(pb_in[n][0]) * RW'(lb_in[0]) + RW'(pb_in[n][1]) * RW'(lb_in[1])
                       + RW'(pb_in[n][2]) * RW'(lb_in[2]);
        end
        for (int k = 0; k < 3; k++)
        begin
            ra_next[k]           = ra_next[k] + (RW'(la_in[k]) << FSH);
            rb_next[FACE_B0 + k] = rb_next[FACE_B0 + k] + (RW'(lb_in[k]) << FSH);
        end
    end

    // Hold valid across stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= up_valid;
    end

    // Capture the beat
    always_ff @(posedge clk)
    begin
        if (adv && up_valid)
        begin
            pd_reg <= pd_in;
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
    end
endmodule

@@ rtl/obb_cmp.sv @@
module obb_cmp #(
    parameter int POS_WIDTH  = obb_pkg::POS_WIDTH_DEF,
    parameter int AXIS_WIDTH = obb_pkg::AXIS_WIDTH_DEF,
    parameter int LEN_WIDTH  = obb_pkg::LEN_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        up_valid,
    output logic                                        up_ready,
    input  logic [2*AXIS_WIDTH+POS_WIDTH+3:0]           pd_in [obb_pkg::NUM_AXES],
    input  logic [3*AXIS_WIDTH+LEN_WIDTH+4:0]           ra_in [obb_pkg::NUM_AXES],
    input  logic [3*AXIS_WIDTH+LEN_WIDTH+4:0]           rb_in [obb_pkg::NUM_AXES],
    output logic                                        dn_valid,
    input  logic                                        dn_ready,
    output logic                                        hit_reg
);
    import obb_pkg::*;

    localparam int FR   = AXIS_WIDTH - 2;
    localparam int PD   = 2 * AXIS_WIDTH + POS_WIDTH + 4;
    localparam int RW   = 3 * AXIS_WIDTH + LEN_WIDTH + 5;
    localparam int LW   = PD + FR;
    localparam int CMPW = ((LW > RW + 1) ? LW : RW + 1) + 1;

    logic                 valid_reg;
    logic                 adv;
    logic [NUM_AXES-1:0]  sep;

    assign adv      = !valid_reg || dn_ready;
    assign up_ready = adv;
    assign dn_valid = valid_reg;

    // Flag every axis whose center distance exceeds the radius sum
    always_comb
    begin
        for (int n = 0; n < NUM_AXES; n++)
            sep[n] = (CMPW'(pd_in[n]) << FR) > (CMPW'(ra_in[n]) + CMPW'(rb_in[n]));
    end

    // Hold valid across stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= up_valid;
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (adv && up_valid)
            hit_reg <= ~(|sep);
    end
endmodule

@@ bench/obb_overlap_test_tb.sv @@
module obb_overlap_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = obb_pkg::POS_WIDTH_DEF;
    localparam int AW = obb_pkg::AXIS_WIDTH_DEF;
    localparam int LW = obb_pkg::LEN_WIDTH_DEF;
    localparam int AFRAC = AW - 2;
    localparam int ONE = 1 << AFRAC;
    localparam int NUM_RANDOM = 1330;
    localparam int LATENCY = 4;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [63:0] comp_t;
    typedef comp_t vec_t [3];

    typedef struct {
        logic [3*PW-1:0] ac;
        logic [3*AW-1:0] a0, a1, a2;
        logic [3*LW-1:0] al;
        logic [3*PW-1:0] bc;
        logic [3*AW-1:0] b0, b1, b2;
        logic [3*LW-1:0] bl;
    } box_pair_t;

    // Directed row: stimulus plus optional typed-in answer (-1 means predict)
    typedef struct {
        box_pair_t pair;
        int        known_hit;
    } pair_row_t;

    logic clk;
    logic rst_n;
    obb_in_if  #(.POS_WIDTH(PW), .AXIS_WIDTH(AW), .LEN_WIDTH(LW)) box_in ();
    obb_out_if res_out ();

    obb_overlap_test #(.POS_WIDTH(PW), .AXIS_WIDTH(AW), .LEN_WIDTH(LW)) dut (
        .clk(clk), .rst_n(rst_n), .box_in(box_in.sink), .res_out(res_out.source)
    );

    logic hit_queue [$];
    int   fail_count = 0;
    int   beats_sent = 0;
    int   hits_seen = 0;
    int   misses_seen = 0;
    int   send_idle_pct = 7;
    int   recv_idle_pct = 55;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("obb_overlap_test regression: fail");
        $finish;
    end

    function automatic vec_t unpack3(input logic [63:0] packed_v, input int w);
        vec_t r;
        logic [63:0] f;
        for (int k = 0; k < 3; k++)
        begin
            f = (packed_v >> (k * w)) & ((64'd1 << w) - 1);
            r[k] = f[w-1] ? comp_t'(f) - comp_t'(64'd1 << w) : comp_t'(f);
        end
        return r;
    endfunction

    function automatic wide_t dot3(input vec_t a, input vec_t b);
        return wide_t'(a[0]) * wide_t'(b[0]) + wide_t'(a[1]) * wide_t'(b[1])
             + wide_t'(a[2]) * wide_t'(b[2]);
    endfunction

    function automatic wide_t mag(input wide_t v);
        return v < 0 ? -v : v;
    endfunction

    // Projected radius of a box, leaving out axis skip (3 keeps all)
    function automatic wide_t box_radius(input vec_t s, input vec_t e [3],
                                         input wide_t len [3], input int skip);
        wide_t sum;
        sum = 0;
        for (int k = 0; k < 3; k++)
            if (k != skip) sum += mag(dot3(s, e[k])) * len[k];
        return sum;
    endfunction

    function automatic logic axis_splits(input vec_t s, input vec_t d,
                                         input wide_t ra, input wide_t rb);
        return (mag(dot3(s, d)) <<< AFRAC) > (ra + rb);
    endfunction

    function automatic logic predict_overlap(input box_pair_t p);
        vec_t ca, cb, d, s;
        vec_t na [3];
        vec_t nb [3];
        wide_t la [3];
        wide_t lb [3];
        logic overlap;
        ca = unpack3(64'(p.ac), PW);
        cb = unpack3(64'(p.bc), PW);
        na[0] = unpack3(64'(p.a0), AW);
        na[1] = unpack3(64'(p.a1), AW);
        na[2] = unpack3(64'(p.a2), AW);
        nb[0] = unpack3(64'(p.b0), AW);
        nb[1] = unpack3(64'(p.b1), AW);
        nb[2] = unpack3(64'(p.b2), AW);
        overlap = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = ca[i] - cb[i];
            la[i] = wide_t'((p.al >> (i * LW)) & ((1 << LW) - 1));
            lb[i] = wide_t'((p.bl >> (i * LW)) & ((1 << LW) - 1));
        end
        // Face axes of both boxes
        for (int i = 0; i < 3; i++)
        begin
            if (axis_splits(na[i], d, la[i] <<< (2 * AFRAC), box_radius(na[i], nb, lb, 3)))
                overlap = 1'b0;
            if (axis_splits(nb[i], d, box_radius(nb[i], na, la, 3), lb[i] <<< (2 * AFRAC)))
                overlap = 1'b0;
        end
        // Edge-edge cross axes
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                s[0] = na[i][1] * nb[j][2] - na[i][2] * nb[j][1];
                s[1] = na[i][2] * nb[j][0] - na[i][0] * nb[j][2];
                s[2] = na[i][0] * nb[j][1] - na[i][1] * nb[j][0];
                if (axis_splits(s, d, box_radius(s, na, la, i), box_radius(s, nb, lb, j)))
                    overlap = 1'b0;
            end
        return overlap;
    endfunction

    function automatic logic [3*PW-1:0] pos3(input int x, input int y, input int z);
        return {PW'(z), PW'(y), PW'(x)};
    endfunction

    function automatic logic [3*AW-1:0] ax3(input int x, input int y, input int z);
        return {AW'(z), AW'(y), AW'(x)};
    endfunction

    function automatic logic [3*LW-1:0] len3(input int x, input int y, input int z);
        return {LW'(z), LW'(y), LW'(x)};
    endfunction

    function automatic box_pair_t aligned(input int dx, input int ha, input int hb);
        box_pair_t p;
        p.ac = pos3(dx, 0, 0);
        p.bc = pos3(0, 0, 0);
        p.a0 = ax3(ONE, 0, 0);
        p.a1 = ax3(0, ONE, 0);
        p.a2 = ax3(0, 0, ONE);
        p.b0 = p.a0;
        p.b1 = p.a1;
        p.b2 = p.a2;
        p.al = len3(ha, ha, ha);
        p.bl = len3(hb, hb, hb);
        return p;
    endfunction

    function automatic logic [3*AW-1:0] rand_axis();
        logic [3*AW-1:0] v;
        int c;
        // Mostly near-unit component sets, sometimes raw bits
        if ($urandom_range(0, 9) == 0)
            return (3*AW)'({$urandom(), $urandom()});
        for (int k = 0; k < 3; k++)
        begin
            c = $urandom_range(0, ONE);
            if ($urandom_range(0, 1)) c = -c;
            v[k*AW +: AW] = AW'(c);
        end
        return v;
    endfunction

    function automatic box_pair_t rand_pair();
        box_pair_t p;
        int span;
        span = $urandom_range(0, 3) == 0 ? (1 << (PW - 1)) - 1 : 4096;
        for (int k = 0; k < 3; k++)
        begin
            p.ac[k*PW +: PW] = PW'($urandom_range(0, 2 * span) - span);
            p.bc[k*PW +: PW] = PW'($urandom_range(0, 2 * span) - span);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            p.ac = (3*PW)'({$urandom(), $urandom()});
            p.bc = (3*PW)'({$urandom(), $urandom()});
        end
        p.a0 = rand_axis();
        p.a1 = rand_axis();
        p.a2 = rand_axis();
        p.b0 = rand_axis();
        p.b1 = rand_axis();
        p.b2 = rand_axis();
        if ($urandom_range(0, 3) == 0)
        begin
            p.al = (3*LW)'({$urandom(), $urandom()});
            p.bl = (3*LW)'({$urandom(), $urandom()});
        end
        else
        begin
            p.al = len3($urandom_range(0, 4096), $urandom_range(0, 4096),
                        $urandom_range(0, 4096));
            p.bl = len3($urandom_range(0, 4096), $urandom_range(0, 4096),
                        $urandom_range(0, 4096));
        end
        return p;
    endfunction

    task automatic drive_pair(input box_pair_t p);
        // Insert sender gaps
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            box_in.valid <= 1'b0;
            @(negedge clk);
        end
        box_in.valid          <= 1'b1;
        box_in.a_center       <= p.ac;
        box_in.a_axis_first   <= p.a0;
        box_in.a_axis_second  <= p.a1;
        box_in.a_axis_third   <= p.a2;
        box_in.a_half_lengths <= p.al;
        box_in.b_center       <= p.bc;
        box_in.b_axis_first   <= p.b0;
        box_in.b_axis_second  <= p.b1;
        box_in.b_axis_third   <= p.b2;
        box_in.b_half_lengths <= p.bl;
        @(posedge clk);
        while (!box_in.ready) @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_pair(input box_pair_t p);
        hit_queue.push_back(predict_overlap(p));
        drive_pair(p);
    endtask

    task automatic drain();
        box_in.valid <= 1'b0;
        while (hit_queue.size() != 0) @(negedge clk);
    endtask

    // Receiver stall pattern
    always @(negedge clk)
        res_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Check result beats in order
    always @(posedge clk)
    begin
        logic want;
        if (rst_n && res_out.valid && res_out.ready)
        begin
            if (hit_queue.size() == 0)
            begin
                $error("unexpected result beat, hit=%0b", res_out.hit);
                fail_count++;
            end
            else
            begin
                want = hit_queue.pop_front();
                if (res_out.hit !== want)
                begin
                    $error("field hit: expected %0b, actual %0b", want, res_out.hit);
                    fail_count++;
                end
                if (want) hits_seen++;
                else misses_seen++;
            end
        end
    end

    initial
    begin
        pair_row_t rows [$];
        pair_row_t r;
        box_pair_t p;
        rst_n = 1'b0;
        box_in.valid = 1'b0;
        box_in.a_center = '0;
        box_in.a_axis_first = '0;
        box_in.a_axis_second = '0;
        box_in.a_axis_third = '0;
        box_in.a_half_lengths = '0;
        box_in.b_center = '0;
        box_in.b_axis_first = '0;
        box_in.b_axis_second = '0;
        box_in.b_axis_third = '0;
        box_in.b_half_lengths = '0;
        res_out.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: aligned cubes, touching, separated, extremes
        r.pair = aligned(0, 256, 256);          r.known_hit = 1; rows.push_back(r);
        r.pair = aligned(512, 256, 256);        r.known_hit = 1; rows.push_back(r);
        r.pair = aligned(513, 256, 256);        r.known_hit = 0; rows.push_back(r);
        r.pair = aligned(-513, 256, 256);       r.known_hit = 0; rows.push_back(r);
        r.pair = aligned(0, 0, 0);              r.known_hit = 1; rows.push_back(r);
        r.pair = aligned(1, 0, 0);              r.known_hit = 0; rows.push_back(r);
        r.pair = aligned((1 << (PW - 1)) - 1, 65535, 65535); r.known_hit = -1;
        rows.push_back(r);
        r.pair = aligned(-(1 << (PW - 1)), 65535, 65535); r.known_hit = -1;
        rows.push_back(r);
        // Zero-length axes: every projection vanishes
        p = aligned(100000, 100, 100);
        p.a0 = '0; p.a1 = '0; p.a2 = '0; p.b0 = '0; p.b1 = '0; p.b2 = '0;
        r.pair = p; r.known_hit = 1; rows.push_back(r);
        // All ones in every field
        p.ac = '1; p.bc = '1; p.a0 = '1; p.a1 = '1; p.a2 = '1;
        p.b0 = '1; p.b1 = '1; p.b2 = '1; p.al = '1; p.bl = '1;
        r.pair = p; r.known_hit = -1; rows.push_back(r);
        // Most negative axis components, extreme centers apart
        p = aligned(0, 65535, 0);
        p.a0 = ax3(-32768, -32768, -32768); p.b1 = ax3(32767, -32768, 32767);
        p.ac = pos3(524287, -524288, 524287); p.bc = pos3(-524288, 524287, -524288);
        r.pair = p; r.known_hit = -1; rows.push_back(r);
        // Rotated B (45 deg about z), skewed and non-unit axes
        p = aligned(600, 256, 256);
        p.b0 = ax3(11585, 11585, 0); p.b1 = ax3(-11585, 11585, 0);
        r.pair = p; r.known_hit = -1; rows.push_back(r);
        p.ac = pos3(700, 0, 0); r.pair = p; rows.push_back(r);
        p.a1 = ax3(ONE, ONE, 0); p.b2 = ax3(0, 0, 2 * ONE - 1);
        r.pair = p; rows.push_back(r);
        p = aligned(0, 200, 0); p.bc = pos3(0, 400, 400);
        r.pair = p; r.known_hit = -1; rows.push_back(r);

        foreach (rows[n])
        begin
            if (rows[n].known_hit >= 0 &&
                rows[n].known_hit != int'(predict_overlap(rows[n].pair)))
            begin
                $error("field hit: table row %0d predicted %0b, typed %0d", n,
                       predict_overlap(rows[n].pair), rows[n].known_hit);
                fail_count++;
            end
            if (rows[n].known_hit >= 0)
            begin
                hit_queue.push_back(rows[n].known_hit[0]);
                drive_pair(rows[n].pair);
            end
            else
                send_pair(rows[n].pair);
        end

        // Random part in three idle regimes, with a full pause between
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 7 : 0;
            for (int n = 0; n < NUM_RANDOM / 3; n++)
            begin
                // Close pairs often, so both outcomes appear
                p = rand_pair();
                if ($urandom_range(0, 1)) p.bc = p.ac ^ (3*PW)'($urandom_range(0, 1023));
                send_pair(p);
            end
            drain();
        end

        repeat (LATENCY + 4) @(negedge clk);
        $display("sent %0d box pairs; %0d overlapping, %0d separated", beats_sent,
                 hits_seen, misses_seen);
        $display("covered aligned, touching, rotated, skewed and extreme-valued boxes");
        if (fail_count == 0 && hit_queue.size() == 0)
            $display("obb_overlap_test regression: pass");
        else
            $display("obb_overlap_test regression: fail");
        $finish;
    end
endmodule

@@ obb_overlap_test.f @@
rtl/obb_pkg.sv
rtl/obb_in_if.sv
rtl/obb_out_if.sv
rtl/obb_prep.sv
rtl/obb_proj.sv
rtl/obb_rad.sv
rtl/obb_cmp.sv
rtl/obb_overlap_test.sv
bench/obb_overlap_test_tb.sv
